### hdl/ternary_base3_dot_product_unit_assert.svh
// Assertion macros for the ternary base-3 dot product unit.
// Expects clk and arst_n in the scope of the including module.
`ifndef TERNARY_BASE3_DOT_PRODUCT_UNIT_ASSERT_SVH
`define TERNARY_BASE3_DOT_PRODUCT_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication: when ante holds, cons holds at that edge.
`define TBDP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication: when ante holds, cons holds at the following edge.
`define TBDP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TBDP_ASSERT_NOW(lbl, ante, cons)
`define TBDP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hdl/tbdp_pkg.sv
// Shared types and constants for the ternary base-3 dot product unit.
// No dependencies.
package tbdp_pkg;

	localparam int ACT_W    = 16;
	localparam int SCALE_W  = 17;
	localparam int WORD_W   = 32;
	localparam int PROD_W   = 33;
	localparam int ACC_W    = 48;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// Reciprocal of three for a 32-bit dividend: q = (x * RECIP3) >> 33.
	localparam logic [WORD_W-1:0] RECIP3 = 32'hAAAA_AAAB;
	localparam int RECIP3_SHIFT = 33;

	typedef enum logic [1:0] {
		TRIT_ZERO = 2'd0,
		TRIT_POS  = 2'd1,
		TRIT_NEG  = 2'd2
	} trit_t;

	typedef struct packed {
		logic signed [ACT_W-1:0] activation;
		logic [SCALE_W-1:0]      block_scale;
		trit_t                   trit;
		logic                    last;
	} item_t;

	typedef struct packed {
		logic valid;
		logic full;
	} queue_status_t;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Base-3 digit to trit: 1 is +1, 2 is -1, 0 and the unused code are 0.
	function automatic trit_t digit_to_trit(input logic [1:0] digit);
		trit_t t;
		case (digit)
			2'd1:    t = TRIT_POS;
			2'd2:    t = TRIT_NEG;
			default: t = TRIT_ZERO;
		endcase
		return t;
	endfunction

endpackage

### hdl/ternary_base3_dot_product_unit.sv
// Ternary base-3 dot product unit: top level joining front end, queue and back end.
// Depends on tbdp_pkg, tbdp_front, tbdp_queue, tbdp_back and the assertion header.
//
// The unit takes one request per clock cycle while item_stall is low, each carrying
// an activation, its block scale and a last-of-row flag, and on the first request
// of every group of TRITS_PER_WORD also a packed word of base-3 weight digits. The
// front end peels one digit per request with a reciprocal multiply, turns it into a
// trit (+1, -1 or 0) and hands the request to a two-entry queue. The back end pops
// the queue, forms activation times scale in one registered multiply, and adds,
// subtracts or skips it in a 48-bit saturating accumulator. A request marked last
// of row produces one result, the row sum including that request; it passes the
// queue slot, the product register and the result register, and result_valid
// rises when the sum is loaded. The accumulator and digit position then restart.
// Throughput is one request per cycle while item_stall is low, set by the digit
// peel in the front end and the single accumulator add in the back end. item_stall
// rises only when the queue is full, which happens when result_stall holds results back.
module ternary_base3_dot_product_unit #(
	parameter int TRITS_PER_WORD = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic [tbdp_pkg::WORD_W-1:0]          packed_word,
	input  logic signed [tbdp_pkg::ACT_W-1:0]    activation,
	input  logic [tbdp_pkg::SCALE_W-1:0]         block_scale,
	input  logic                                 last_of_row,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [tbdp_pkg::ACC_W-1:0]    dot_product
);

	`include "ternary_base3_dot_product_unit_assert.svh"

	logic                    accept;
	logic                    idx_zero;
	logic                    pop;
	tbdp_pkg::item_t         front_item;
	tbdp_pkg::item_t         head;
	tbdp_pkg::queue_status_t qstat;

	// A request is taken whenever the queue has room.
	assign item_stall = qstat.full;
	assign accept     = item_valid && !qstat.full;

	tbdp_front #(
		.TRITS_PER_WORD(TRITS_PER_WORD)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.packed_word (packed_word),
		.activation  (activation),
		.block_scale (block_scale),
		.last_of_row (last_of_row),
		.item        (front_item),
		.idx_zero    (idx_zero)
	);

	tbdp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_item (front_item),
		.pop       (pop),
		.head      (head),
		.status    (qstat)
	);

	tbdp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.dot_product  (dot_product)
	);

	// The back end never pops an empty queue.
	`TBDP_ASSERT_NOW(a_pop_nonempty, pop, qstat.valid)
	// A full queue is also a non-empty queue.
	`TBDP_ASSERT_NOW(a_full_valid, qstat.full, qstat.valid)
	// The end of a row restarts the digit position, so the next request latches a word.
	`TBDP_ASSERT_NEXT(a_row_restart, accept && last_of_row, idx_zero)

endmodule

### hdl/tbdp_front.sv
// Front end: accepts requests, peels one base-3 digit per request and emits a
// classified item toward the queue. Depends on tbdp_pkg.
module tbdp_front #(
	parameter int TRITS_PER_WORD = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic [tbdp_pkg::WORD_W-1:0]          packed_word,
	input  logic signed [tbdp_pkg::ACT_W-1:0]    activation,
	input  logic [tbdp_pkg::SCALE_W-1:0]         block_scale,
	input  logic                                 last_of_row,
	output tbdp_pkg::item_t                      item,
	output logic                                 idx_zero
);

	localparam int IDX_W = (TRITS_PER_WORD > 1) ? $clog2(TRITS_PER_WORD) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TRITS_PER_WORD - 1);

	logic [tbdp_pkg::WORD_W-1:0]   rem_q;
	logic [IDX_W-1:0]              idx_q;
	logic [tbdp_pkg::WORD_W-1:0]   cur;
	logic [2*tbdp_pkg::WORD_W-1:0] recip_prod;
	logic [tbdp_pkg::WORD_W-2:0]   quot;
	logic [tbdp_pkg::WORD_W-1:0]   quot3;
	logic [tbdp_pkg::WORD_W-1:0]   diff;

	assign idx_zero   = (idx_q == '0);
	assign cur        = idx_zero ? packed_word : rem_q;
	assign recip_prod = cur * tbdp_pkg::RECIP3;
	assign quot       = recip_prod[2*tbdp_pkg::WORD_W-1:tbdp_pkg::RECIP3_SHIFT];
	assign quot3      = {quot, 1'b0} + {1'b0, quot};
	assign diff       = cur - quot3;

	assign item.activation  = activation;
	assign item.block_scale = block_scale;
	assign item.trit        = tbdp_pkg::digit_to_trit(diff[1:0]);
	assign item.last        = last_of_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (accept) begin
			rem_q <= {1'b0, quot};
			if (last_of_row || idx_q == IDX_LAST) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

### hdl/tbdp_queue.sv
// Two-entry queue that decouples the front end from the multiply-accumulate
// back end. Depends on tbdp_pkg.
module tbdp_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  tbdp_pkg::item_t         push_item,
	input  logic                    pop,
	output tbdp_pkg::item_t         head,
	output tbdp_pkg::queue_status_t status
);

	tbdp_pkg::item_t                 slot_q [tbdp_pkg::QUEUE_DEPTH];
	logic [tbdp_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [tbdp_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [tbdp_pkg::QCNT_W-1:0]     count_q;

	localparam logic [tbdp_pkg::QPTR_W-1:0] PTR_LAST =
		tbdp_pkg::QPTR_W'(tbdp_pkg::QUEUE_DEPTH - 1);
	localparam logic [tbdp_pkg::QCNT_W-1:0] CNT_FULL =
		tbdp_pkg::QCNT_W'(tbdp_pkg::QUEUE_DEPTH);

	assign head         = slot_q[rd_ptr_q];
	assign status.valid = (count_q != '0);
	assign status.full  = (count_q == CNT_FULL);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/tbdp_back.sv
// Back end: multiplies activation by block scale, applies the trit, keeps the
// saturating row accumulator and holds the result register. Depends on tbdp_pkg.
module tbdp_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tbdp_pkg::item_t                      head,
	input  tbdp_pkg::queue_status_t              qstat,
	output logic                                 pop,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [tbdp_pkg::ACC_W-1:0]    dot_product
);

	logic                                 valid_s1;
	logic signed [tbdp_pkg::PROD_W-1:0]   prod_s1;
	tbdp_pkg::trit_t                      trit_s1;
	logic                                 last_s1;
	logic signed [tbdp_pkg::ACC_W-1:0]    acc_q;
	logic                                 res_valid_q;
	logic signed [tbdp_pkg::ACC_W-1:0]    res_q;

	logic                                 out_free;
	logic                                 take_s1;
	logic signed [tbdp_pkg::SCALE_W:0]    scale_sx;
	logic signed [tbdp_pkg::PROD_W:0]     prod_full;
	logic signed [tbdp_pkg::PROD_W:0]     term;
	logic signed [tbdp_pkg::ACC_W:0]      sum;
	logic signed [tbdp_pkg::ACC_W-1:0]    acc_next;

	assign out_free = !res_valid_q || !result_stall;
	assign take_s1  = valid_s1 && (!last_s1 || out_free);
	assign pop      = qstat.valid && (!valid_s1 || take_s1);

	assign scale_sx  = $signed({1'b0, head.block_scale});
	assign prod_full = head.activation * scale_sx;

	always_comb begin
		case (trit_s1)
			tbdp_pkg::TRIT_POS: term = (tbdp_pkg::PROD_W+1)'(prod_s1);
			tbdp_pkg::TRIT_NEG: term = -(tbdp_pkg::PROD_W+1)'(prod_s1);
			default:            term = '0;
		endcase
		sum = (tbdp_pkg::ACC_W+1)'(acc_q) + (tbdp_pkg::ACC_W+1)'(term);
		if (sum[tbdp_pkg::ACC_W] != sum[tbdp_pkg::ACC_W-1]) begin
			acc_next = sum[tbdp_pkg::ACC_W] ? tbdp_pkg::ACC_MIN : tbdp_pkg::ACC_MAX;
		end else begin
			acc_next = sum[tbdp_pkg::ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1 <= prod_full[tbdp_pkg::PROD_W-1:0];
			trit_s1 <= head.trit;
			last_s1 <= head.last;
		end
		if (take_s1 && last_s1) begin
			res_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			acc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
			if (take_s1) begin
				acc_q <= last_s1 ? '0 : acc_next;
			end
			if (take_s1 && last_s1) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign dot_product  = res_q;

endmodule
